>>> hdl/pcu_pkg.sv
// Shared types and constants for the polynomial convolution unit.
// No dependencies; imported by pcu_cell and polynomial_convolution_unit.
`timescale 1ns / 1ps

package pcu_pkg;

    localparam int COEF_PORT_W = 16;
    localparam int PROD_W      = 36;
    localparam int POS_W       = 6;

    // op field codes
    localparam logic OP_FIRST  = 1'b0;
    localparam logic OP_SECOND = 1'b1;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic en;      // chain advances this cycle
        logic load;    // request writes a first-vector coefficient
    } t_cell_ctl;

endpackage

>>> hdl/polynomial_convolution_unit.sv
// Top level of the polynomial convolution unit: load control, second-vector
// store, sample sequencer and the chain of pcu_cell taps.
// Depends on pcu_pkg and pcu_cell.
//
//  Channel  Handshake             Payload
//  -------  --------------------  ------------------------------------------
//  load     i_valid / o_ready     i_op, i_coefficient, i_last
//  result   o_valid / i_ready     o_product, o_position, o_final_res, o_overflow
//
// A load request is accepted when i_valid and o_ready are both high. After the
// request with i_last, a run of R results (R = first + second count - 1, or 1 if a
// vector is empty) passes the store read, the tap multiply and the partial-sum
// register at the head of the chain, one result per cycle unless i_ready stalls it.
// Loads are refused from the last request until the final result is taken.
// A low i_ready while a result waits freezes the whole chain. Reset empties
// both vectors.
`timescale 1ns / 1ps

module polynomial_convolution_unit
    import pcu_pkg::*;
#(
    parameter int MAX_TERMS  = 16,
    parameter int COEFF_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic                   i_op,
    input  logic [COEF_PORT_W-1:0] i_coefficient,
    input  logic                   i_last,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [PROD_W-1:0]      o_product,
    output logic [POS_W-1:0]       o_position,
    output logic                   o_final_res,
    output logic                   o_overflow
);

    localparam int CW   = (COEFF_BITS < COEF_PORT_W) ? COEFF_BITS : COEF_PORT_W;
    localparam int CNTW = $clog2(MAX_TERMS + 1);
    localparam int IW   = $clog2(MAX_TERMS);
    localparam int PW   = $clog2(2 * MAX_TERMS);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [CNTW-1:0] r_fcnt, r_scnt;
    logic            r_dropped;
    logic [CW-1:0]   r_b [MAX_TERMS];
    logic [PW-1:0]   r_t;

    // tag pipeline: A = sample, B = product, C = partial sum at chain head
    logic            r_va, r_vb, r_vc;
    logic [PW-1:0]   r_posa, r_posb, r_posc;
    logic            r_fina, r_finb, r_finc;
    logic [CW-1:0]   r_x;

    logic            w_accept, w_en, w_issue, w_done;
    logic            w_f_room, w_s_room;
    logic [PW-1:0]   w_total;
    logic [CW-1:0]   w_coef;
    t_cell_ctl       w_ctl;
    logic [PROD_W-1:0] w_psum [MAX_TERMS+1];

    assign o_ready  = (r_state == ST_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_coef   = i_coefficient[CW-1:0];
    assign w_f_room = r_fcnt < CNTW'(MAX_TERMS);
    assign w_s_room = r_scnt < CNTW'(MAX_TERMS);

    assign w_en    = !r_vc || i_ready;
    assign w_issue = (r_state == ST_RUN) && w_en;
    assign w_done  = r_vc && i_ready && r_finc;

    assign w_total = (r_fcnt == '0 || r_scnt == '0) ? PW'(1)
                   : PW'(r_fcnt) + PW'(r_scnt) - PW'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (w_accept && i_last) n_state = ST_RUN;
            ST_RUN:   if (w_issue && r_t == w_total - PW'(1)) n_state = ST_DRAIN;
            ST_DRAIN: if (w_done) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_fcnt    <= '0;
            r_scnt    <= '0;
            r_dropped <= 1'b0;
            r_t       <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                if (i_op == OP_FIRST) begin
                    if (w_f_room) r_fcnt <= r_fcnt + CNTW'(1);
                    else          r_dropped <= 1'b1;
                end else begin
                    if (w_s_room) r_scnt <= r_scnt + CNTW'(1);
                    else          r_dropped <= 1'b1;
                end
            end else if (w_done) begin
                r_fcnt    <= '0;
                r_scnt    <= '0;
                r_dropped <= 1'b0;
            end
            if (w_issue) begin
                r_t <= r_t + PW'(1);
            end else if (r_state == ST_IDLE) begin
                r_t <= '0;
            end
        end
    end

    // second-vector store
    always_ff @(posedge i_clk) begin
        if (w_accept && i_op == OP_SECOND && w_s_room) begin
            r_b[r_scnt[IW-1:0]] <= w_coef;
        end
    end

    // sample stream: stored coefficients, then zeros to flush the chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= '0;
        end else if (w_en) begin
            if (w_issue && PW'(r_scnt) > r_t) r_x <= r_b[r_t[IW-1:0]];
            else                              r_x <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
        end else if (w_en) begin
            r_va <= w_issue;
            r_vb <= r_va;
            r_vc <= r_vb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_posa <= r_t;
            r_fina <= (r_t == w_total - PW'(1));
            r_posb <= r_posa;
            r_finb <= r_fina;
            r_posc <= r_posb;
            r_finc <= r_finb;
        end
    end

    assign w_ctl.en   = w_en;
    assign w_ctl.load = w_accept && i_op == OP_FIRST;

    assign w_psum[MAX_TERMS] = '0;

    for (genvar g = 0; g < MAX_TERMS; g++) begin : g_cell
        pcu_cell #(
            .INDEX (g),
            .CW    (CW),
            .CNTW  (CNTW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_count (r_fcnt),
            .i_coef  (w_coef),
            .i_x     (r_x),
            .i_psum  (w_psum[g+1]),
            .o_psum  (w_psum[g])
        );
    end

    assign o_valid     = r_vc;
    assign o_product   = w_psum[0];
    assign o_position  = POS_W'(r_posc);
    assign o_final_res = r_finc;
    assign o_overflow  = r_dropped;

endmodule

>>> hdl/pcu_cell.sv
// One tap of the transposed convolution chain: holds one first-vector
// coefficient, multiplies the broadcast sample and adds the neighbor's sum.
// Depends on pcu_pkg.
`timescale 1ns / 1ps

module pcu_cell
    import pcu_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CW    = 16,
    parameter int CNTW  = 5
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [CNTW-1:0]   i_count,
    input  logic [CW-1:0]     i_coef,
    input  logic [CW-1:0]     i_x,
    input  logic [PROD_W-1:0] i_psum,
    output logic [PROD_W-1:0] o_psum
);

    logic [CW-1:0]     r_a;
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] r_psum;
    logic [2*CW-1:0]   w_mul;
    logic              w_active;

    // taps at or above the loaded count contribute nothing
    assign w_active = CNTW'(INDEX) < i_count;
    assign w_mul    = r_a * i_x;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && i_count == CNTW'(INDEX)) begin
            r_a <= i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod <= '0;
            r_psum <= '0;
        end else if (i_ctl.en) begin
            r_prod <= w_active ? PROD_W'(w_mul) : '0;
            r_psum <= r_prod + i_psum;
        end
    end

    assign o_psum = r_psum;

endmodule
